[rtl/assert_macros.svh]
// Assertion macros used by the checker file of the plan cache.
// Needs nothing else; take it in with a bare include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, held off while reset is low.
`define AST_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property checked through reset as well.
`define AST_ANY(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/lkpc_pkg.sv]
// Shared types and constants of the LRU keyed plan cache.
// Used by the controller, the datapath, the top level and the checker.
package lkpc_pkg;

    localparam int ENTRIES_DEF = 32;

    localparam int KEY_W       = 64;
    localparam int SLOT_W      = 5;
    localparam int LIMIT_W     = 6;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 6'd32;

    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 136;
    localparam int OUT_TUSER_W = 2;

    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    // register index codes (byte address 4*i)
    localparam logic [0:0] REG_SIZE_LIMIT = 1'b0;

    typedef struct packed {
        logic start;   // latch key, clear scan trackers
        logic scan;    // read one key entry, advance the scan counter
        logic update;  // commit directory update and load the result
    } t_cmd;

    typedef struct packed {
        logic scan_last;  // scan counter at the last entry
        logic out_busy;   // result register full and not taken this cycle
    } t_sts;

    typedef struct packed {
        logic                 hit;
        logic [SLOT_W-1:0]    slot;
        logic                 evicted;
        logic [KEY_W-1:0]     ev_query_id;
        logic [KEY_W-1:0]     ev_collection_id;
    } t_result;

endpackage

[rtl/lru_keyed_plan_cache.sv]
// Steps: input transfer in idle, scan of every key entry, compare of the last word in drain,
// then update, which waits while the result register is stalled. The scan reads the key store
// through its single read port one entry per cycle; the next lookup is taken back in idle.
// Reset (synchronous, i_rst_n low) clears valid bits, recency ranks and occupancy at
// once, with no clearing pass; size_limit returns to 32. Key words are not reset.
module lru_keyed_plan_cache #(
    parameter int ENTRIES = lkpc_pkg::ENTRIES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // lookup stream in
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // [63:0] collection_id, [127:64] query_id
    input  logic [lkpc_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // result stream out
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [4:0] slot, [68:5] evicted_collection_id, [132:69] evicted_query_id, rest zero
    output logic [lkpc_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // [0] hit, [1] evicted
    output logic [lkpc_pkg::OUT_TUSER_W-1:0]    o_m_tuser,
    // configuration port
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic [lkpc_pkg::APB_ADDR_W-1:0]     i_paddr,
    input  logic [lkpc_pkg::APB_DATA_W-1:0]     i_pwdata,
    output logic [lkpc_pkg::APB_DATA_W-1:0]     o_prdata,
    output logic                                o_pready
);

    logic [lkpc_pkg::LIMIT_W-1:0]      r_size_limit;
    logic                              r_m_tvalid;
    logic [lkpc_pkg::OUT_TDATA_W-1:0]  r_m_tdata;
    logic [lkpc_pkg::OUT_TUSER_W-1:0]  r_m_tuser;

    lkpc_pkg::t_cmd    cmd;
    lkpc_pkg::t_sts    sts;
    lkpc_pkg::t_result res;
    logic              scan_last;
    logic              reg_sel;

    // Register file: size_limit only, written in the access phase.
    assign o_pready = 1'b1;
    assign reg_sel  = (i_paddr[2] == lkpc_pkg::REG_SIZE_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_limit <= lkpc_pkg::LIMIT_RST;
        end else if (i_psel && i_penable && i_pwrite && reg_sel) begin
            r_size_limit <= i_pwdata[lkpc_pkg::LIMIT_W-1:0];
        end
    end

    assign o_prdata = reg_sel ? lkpc_pkg::APB_DATA_W'(r_size_limit) : '0;

    // The result register is busy only while a transfer is stalled; a result
    // taken this cycle leaves room for the next one.
    assign sts.scan_last = scan_last;
    assign sts.out_busy  = r_m_tvalid && !i_m_tready;

    lkpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lkpc_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_key        (i_s_tdata),
        .i_size_limit (r_size_limit),
        .o_scan_last  (scan_last),
        .o_res        (res)
    );

    // Output register: load on update, drop valid after the transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (cmd.update) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.update) begin
            r_m_tdata <= {3'b000, res.ev_query_id, res.ev_collection_id, res.slot};
            r_m_tuser <= {res.evicted, res.hit};
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

endmodule

[rtl/lkpc_ctrl.sv]
// Controller state machine of the plan cache: input handshake and scan sequencing.
// Depends on lkpc_pkg for the command and status structs.
module lkpc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  lkpc_pkg::t_sts i_sts,
    output lkpc_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_UPDATE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_s_tready   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            // last read word is compared here
            ST_DRAIN: begin
                n_state = ST_UPDATE;
            end
            // hold until the result register can take the result
            ST_UPDATE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.update = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/lkpc_dp.sv]
// Datapath of the plan cache: key store memory, valid bits, recency ranks, occupancy.
// Depends on lkpc_pkg; driven by lkpc_ctrl commands.
module lkpc_dp #(
    parameter int ENTRIES = lkpc_pkg::ENTRIES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lkpc_pkg::t_cmd                    i_cmd,
    input  logic [lkpc_pkg::IN_TDATA_W-1:0]   i_key,
    input  logic [lkpc_pkg::LIMIT_W-1:0]      i_size_limit,
    output logic                              o_scan_last,
    output lkpc_pkg::t_result                 o_res
);

    localparam int IW = $clog2(ENTRIES);
    localparam int OW = $clog2(ENTRIES + 1);
    localparam int CW = (OW > lkpc_pkg::LIMIT_W) ? OW : lkpc_pkg::LIMIT_W;
    localparam int KW = lkpc_pkg::IN_TDATA_W;

    // key store: {query_id, collection_id} per slot, no reset
    logic [KW-1:0] m_keys [ENTRIES];

    logic [KW-1:0]  r_key;
    logic [IW-1:0]  r_cnt;
    logic           r_rd_vld;
    logic [IW-1:0]  r_rd_idx;
    logic [KW-1:0]  r_rd_data;

    logic           r_valid [ENTRIES];
    logic [IW-1:0]  r_rank  [ENTRIES];
    logic           n_valid [ENTRIES];
    logic [IW-1:0]  n_rank  [ENTRIES];
    logic [OW-1:0]  r_occ;
    logic [OW-1:0]  n_occ;

    logic           r_found;
    logic [IW-1:0]  r_found_idx;
    logic [IW-1:0]  r_found_rank;
    logic           r_old_vld;
    logic [IW-1:0]  r_old_idx;
    logic [IW-1:0]  r_old_rank;
    logic [KW-1:0]  r_ev_key;
    logic           r_free_vld;
    logic [IW-1:0]  r_free_idx;

    logic           cur_valid;
    logic [IW-1:0]  cur_rank;
    logic           cur_match;
    logic [CW-1:0]  lim_raw;
    logic [CW-1:0]  lim_eff;
    logic           evict;
    logic [IW-1:0]  free_idx;

    assign o_scan_last = (r_cnt == IW'(ENTRIES - 1));

    // key store ports: one read during scan, one write on a miss
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_rd_data <= m_keys[r_cnt];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update && !r_found) begin
            m_keys[free_idx] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key <= i_key;
        end
        r_rd_idx <= r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan;
            if (i_cmd.start) begin
                r_cnt <= '0;
            end else if (i_cmd.scan) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // compare stage: one registered key word per cycle
    assign cur_valid = r_valid[r_rd_idx];
    assign cur_rank  = r_rank[r_rd_idx];
    assign cur_match = cur_valid && (r_rd_data == r_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found    <= 1'b0;
            r_old_vld  <= 1'b0;
            r_free_vld <= 1'b0;
        end else if (i_cmd.start) begin
            r_found    <= 1'b0;
            r_old_vld  <= 1'b0;
            r_free_vld <= 1'b0;
        end else if (r_rd_vld) begin
            if (cur_match && !r_found) begin
                r_found <= 1'b1;
            end
            if (cur_valid && (!r_old_vld || cur_rank > r_old_rank)) begin
                r_old_vld <= 1'b1;
            end
            if (!cur_valid && !r_free_vld) begin
                r_free_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            if (cur_match && !r_found) begin
                r_found_idx  <= r_rd_idx;
                r_found_rank <= cur_rank;
            end
            if (cur_valid && (!r_old_vld || cur_rank > r_old_rank)) begin
                r_old_idx  <= r_rd_idx;
                r_old_rank <= cur_rank;
                r_ev_key   <= r_rd_data;
            end
            if (!cur_valid && !r_free_vld) begin
                r_free_idx <= r_rd_idx;
            end
        end
    end

    // limit zero acts as one, limit above the store acts as the store size
    always_comb begin
        lim_raw = CW'(i_size_limit);
        if (lim_raw == '0) begin
            lim_eff = CW'(1);
        end else if (lim_raw > CW'(ENTRIES)) begin
            lim_eff = CW'(ENTRIES);
        end else begin
            lim_eff = lim_raw;
        end
    end

    assign evict = !r_found && r_old_vld && (CW'(r_occ) >= lim_eff) && (r_occ != '0);

    // lowest free slot once the victim is gone
    assign free_idx = (evict && (!r_free_vld || r_old_idx < r_free_idx)) ? r_old_idx
                                                                        : r_free_idx;

    always_comb begin
        n_occ = r_occ;
        for (int i = 0; i < ENTRIES; i++) begin
            n_valid[i] = r_valid[i];
            n_rank[i]  = r_rank[i];
            if (r_found) begin
                if (IW'(i) == r_found_idx) begin
                    n_rank[i] = '0;
                end else if (r_valid[i] && r_rank[i] < r_found_rank) begin
                    n_rank[i] = r_rank[i] + 1'b1;
                end
            end else begin
                if (IW'(i) == free_idx) begin
                    n_valid[i] = 1'b1;
                    n_rank[i]  = '0;
                end else if (evict && IW'(i) == r_old_idx) begin
                    n_valid[i] = 1'b0;
                    n_rank[i]  = '0;
                end else if (r_valid[i]) begin
                    n_rank[i] = r_rank[i] + 1'b1;
                end
            end
        end
        if (!r_found && !evict) begin
            n_occ = r_occ + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
                r_rank[i]  <= '0;
            end
        end else if (i_cmd.update) begin
            r_occ <= n_occ;
            for (int i = 0; i < ENTRIES; i++) begin
                r_valid[i] <= n_valid[i];
                r_rank[i]  <= n_rank[i];
            end
        end
    end

    always_comb begin
        o_res         = '0;
        o_res.hit     = r_found;
        o_res.slot    = r_found ? lkpc_pkg::SLOT_W'(r_found_idx)
                                : lkpc_pkg::SLOT_W'(free_idx);
        o_res.evicted = evict;
        if (evict) begin
            o_res.ev_collection_id = r_ev_key[lkpc_pkg::KEY_W-1:0];
            o_res.ev_query_id      = r_ev_key[KW-1:lkpc_pkg::KEY_W];
        end
    end

endmodule

[rtl/lkpc_checker.sv]
// Port-level checker of the plan cache, bound to the top level below.
// Depends on lkpc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lkpc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [lkpc_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    input logic [lkpc_pkg::OUT_TUSER_W-1:0]  o_m_tuser
);

    `AST_RST(a_m_valid_hold, i_clk, i_rst_n, (o_m_tvalid && !i_m_tready) |=> o_m_tvalid, "result valid dropped while stalled")

    `AST_RST(a_m_data_hold, i_clk, i_rst_n, (o_m_tvalid && !i_m_tready) |=> ($stable(o_m_tdata) && $stable(o_m_tuser)), "result payload changed while stalled")

    `AST_RST(a_evict_key_zero, i_clk, i_rst_n, (o_m_tvalid && !o_m_tuser[1]) |-> (o_m_tdata[132:5] == '0), "evicted key not zero without eviction")

    `AST_RST(a_hit_no_evict, i_clk, i_rst_n, (o_m_tvalid && o_m_tuser[0]) |-> !o_m_tuser[1], "hit reported with eviction")

    `AST_ANY(a_reset_clears, i_clk, !i_rst_n |=> (!o_m_tvalid && o_s_tready), "reset did not clear the result or reopen the input")

endmodule

bind lru_keyed_plan_cache lkpc_checker u_lkpc_checker (.*);
